// File: rtl/nnue_pkg.sv
// Shared types, constants and command codes for the evaluator.
`default_nettype none
package nnue_pkg;
    localparam int Hidden = 256;
    localparam int HW = $clog2(Hidden);
    localparam int NFeat = 768;
    localparam int WDepth = NFeat * Hidden;
    localparam int WAW = $clog2(WDepth);
    localparam int QDepth = 4;
    localparam int QAW = $clog2(QDepth);

    typedef enum logic [2:0] {
        CMD_LOAD_W   = 3'd0,
        CMD_LOAD_B   = 3'd1,
        CMD_LOAD_O   = 3'd2,
        CMD_RESET    = 3'd3,
        CMD_ADD      = 3'd4,
        CMD_SUB      = 3'd5,
        CMD_EVAL     = 3'd6,
        CMD_NONE     = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        REG_OUT_BIAS = 2'd0,
        REG_QUANT_A  = 2'd1,
        REG_QUANT_AB = 2'd2,
        REG_SCALE    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        OP_RESET = 2'd0,
        OP_ADD   = 2'd1,
        OP_SUB   = 2'd2,
        OP_EVAL  = 2'd3
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [WAW-1:0]  row1;
        logic [WAW-1:0]  row2;
        logic            stm;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } back_state_t;
endpackage
`default_nettype wire

// File: rtl/nnue_front.sv
// Front end: accepts requests, performs loads, queues accumulator jobs.
`default_nettype none
module nnue_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [2:0]                   s_cmd,
    input  wire logic [3:0]                   s_piece,
    input  wire logic [5:0]                   s_square,
    input  wire logic [17:0]                  s_load_index,
    input  wire logic signed [15:0]           s_load_value,
    input  wire logic                         s_side_to_move,
    output logic                              wr_w,
    output logic                              wr_b,
    output logic                              wr_o,
    output logic [nnue_pkg::WAW-1:0]          wr_addr,
    output logic [15:0]                       wr_data,
    output logic                              job_valid,
    input  wire logic                         job_ready,
    output nnue_pkg::job_t                    job
);
    nnue_pkg::job_t q_reg [nnue_pkg::QDepth];
    logic [nnue_pkg::QAW-1:0] wp_reg, rp_reg;
    logic [nnue_pkg::QAW:0] cnt_reg;
    logic push, pop, is_job, is_load;
    nnue_pkg::job_t nj;
    logic [3:0] fp;
    logic [9:0] f1, f2;

    // hold loads until every queued and running job is finished
    assign is_load = s_cmd inside {nnue_pkg::CMD_LOAD_W, nnue_pkg::CMD_LOAD_B,
                                   nnue_pkg::CMD_LOAD_O};
    assign s_ready = is_load ? (cnt_reg == '0 && job_ready)
                             : (cnt_reg != (nnue_pkg::QAW+1)'(nnue_pkg::QDepth));
    always_comb begin
        fp = (s_piece < 4'd6) ? s_piece + 4'd6 : s_piece - 4'd6;
        f1 = {s_piece, s_square};
        f2 = {fp, s_square ^ 6'd56};
        nj.row1 = nnue_pkg::WAW'(f1) << nnue_pkg::HW;
        nj.row2 = nnue_pkg::WAW'(f2) << nnue_pkg::HW;
        nj.stm = s_side_to_move;
        is_job = 1'b0;
        nj.op = nnue_pkg::OP_EVAL;
        case (nnue_pkg::cmd_t'(s_cmd))
            nnue_pkg::CMD_RESET: begin is_job = 1'b1; nj.op = nnue_pkg::OP_RESET; end
            nnue_pkg::CMD_ADD: begin is_job = s_piece < 4'd12; nj.op = nnue_pkg::OP_ADD; end
            nnue_pkg::CMD_SUB: begin is_job = s_piece < 4'd12; nj.op = nnue_pkg::OP_SUB; end
            nnue_pkg::CMD_EVAL: begin is_job = 1'b1; nj.op = nnue_pkg::OP_EVAL; end
            default: is_job = 1'b0;
        endcase
    end
    assign push = s_valid && s_ready && is_job;
    assign pop = job_valid && job_ready;
    assign job_valid = cnt_reg != '0;
    assign job = q_reg[rp_reg];

    always_comb begin
        wr_w = s_valid && s_ready && s_cmd == nnue_pkg::CMD_LOAD_W &&
               32'(s_load_index) < nnue_pkg::WDepth;
        wr_b = s_valid && s_ready && s_cmd == nnue_pkg::CMD_LOAD_B &&
               32'(s_load_index) < nnue_pkg::Hidden;
        wr_o = s_valid && s_ready && s_cmd == nnue_pkg::CMD_LOAD_O &&
               32'(s_load_index) < 2 * nnue_pkg::Hidden;
        wr_addr = s_load_index[nnue_pkg::WAW-1:0];
        wr_data = s_load_value;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 1'b1;
            if (pop) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (nnue_pkg::QAW+1)'(push) - (nnue_pkg::QAW+1)'(pop);
        end
        if (push) q_reg[wp_reg] <= nj;
    end
endmodule
`default_nettype wire

// File: rtl/nnue_div.sv
// Signed restoring divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none
module nnue_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [47:0] num,
    input  wire logic [21:0]        den,
    output logic                    busy,
    output logic signed [47:0]      quo
);
    logic [47:0] n_reg;
    logic [22:0] r_reg;
    logic [21:0] d_reg;
    logic neg_reg;
    logic [5:0] k_reg;
    logic [22:0] rs;
    logic [22:0] rd;

    assign rs = {r_reg[21:0], n_reg[47]};
    assign rd = rs - {1'b0, d_reg};
    assign quo = neg_reg ? -$signed(n_reg) : $signed(n_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy <= 1'b0;
            k_reg <= '0;
        end else if (start) begin
            busy <= 1'b1;
            k_reg <= 6'd48;
        end else if (busy) begin
            k_reg <= k_reg - 6'd1;
            if (k_reg == 6'd1) busy <= 1'b0;
        end
        if (start) begin
            n_reg <= num[47] ? 48'(-num) : 48'(num);
            neg_reg <= num[47];
            r_reg <= '0;
            d_reg <= (den == '0) ? 22'd1 : den;
        end else if (busy) begin
            if (!rd[22]) begin
                r_reg <= rd;
                n_reg <= {n_reg[46:0], 1'b1};
            end else begin
                r_reg <= rs;
                n_reg <= {n_reg[46:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/nnue_back.sv
// Back end: weight stores, accumulators, lane walk and eval scaling.
`default_nettype none
module nnue_back (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_w,
    input  wire logic                   wr_b,
    input  wire logic                   wr_o,
    input  wire logic [nnue_pkg::WAW-1:0] wr_addr,
    input  wire logic [15:0]            wr_data,
    input  wire logic                   job_valid,
    output logic                        job_ready,
    input  wire nnue_pkg::job_t         job,
    input  wire logic signed [15:0]     out_bias,
    input  wire logic [15:0]            quant_a,
    input  wire logic [21:0]            quant_ab,
    input  wire logic [11:0]            eval_scale,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic signed [31:0]          m_score
);
    logic signed [15:0] fw_mem [nnue_pkg::WDepth];
    logic signed [15:0] fw2_mem [nnue_pkg::WDepth];
    logic signed [15:0] hb_mem [nnue_pkg::Hidden];
    logic signed [15:0] ow1_mem [nnue_pkg::Hidden];
    logic signed [15:0] ow2_mem [nnue_pkg::Hidden];
    logic [31:0] acc0_mem [nnue_pkg::Hidden];
    logic [31:0] acc1_mem [nnue_pkg::Hidden];

    nnue_pkg::back_state_t st_reg, st_next;
    nnue_pkg::job_t j_reg;
    logic [nnue_pkg::HW:0] h_reg;
    // stage 1 registered reads
    logic p1_reg;
    logic [nnue_pkg::HW-1:0] a1_reg;
    logic signed [15:0] w1_rd, w2_rd, b_rd, o1_rd, o2_rd;
    logic [31:0] c0_rd, c1_rd;
    // stage 2 squares
    logic p2_reg;
    logic [31:0] s0_reg, s1_reg;
    logic signed [15:0] o1_reg, o2_reg;
    // stage 3 products
    logic p3_reg;
    logic [31:0] m0_reg, m1_reg;
    logic [31:0] sum_reg;
    logic [2:0] ph_reg;
    logic signed [47:0] t_reg;
    logic dstart;
    logic signed [47:0] dnum;
    logic [21:0] dden;
    logic dbusy;
    logic signed [47:0] dquo;
    logic [31:0] r0, r1, f0, f1;

    nnue_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .num(dnum),
        .den(dden), .busy(dbusy), .quo(dquo)
    );

    always_ff @(posedge aclk) begin
        if (wr_w) begin
            fw_mem[wr_addr] <= wr_data;
            fw2_mem[wr_addr] <= wr_data;
        end
        if (wr_b) hb_mem[wr_addr[nnue_pkg::HW-1:0]] <= wr_data;
        if (wr_o && !wr_addr[nnue_pkg::HW]) ow1_mem[wr_addr[nnue_pkg::HW-1:0]] <= wr_data;
        if (wr_o && wr_addr[nnue_pkg::HW]) ow2_mem[wr_addr[nnue_pkg::HW-1:0]] <= wr_data;
    end

    logic [nnue_pkg::HW-1:0] ha;
    assign ha = h_reg[nnue_pkg::HW-1:0];
    always_ff @(posedge aclk) begin
        w1_rd <= fw_mem[j_reg.row1 | nnue_pkg::WAW'(ha)];
        w2_rd <= fw2_mem[j_reg.row2 | nnue_pkg::WAW'(ha)];
        b_rd <= hb_mem[ha];
        o1_rd <= ow1_mem[ha];
        o2_rd <= ow2_mem[ha];
        c0_rd <= acc0_mem[ha];
        c1_rd <= acc1_mem[ha];
        a1_reg <= ha;
    end

    always_comb begin
        case (j_reg.op)
            nnue_pkg::OP_RESET: begin r0 = 32'(b_rd); r1 = 32'(b_rd); end
            nnue_pkg::OP_ADD: begin r0 = c0_rd + 32'(w1_rd); r1 = c1_rd + 32'(w2_rd); end
            nnue_pkg::OP_SUB: begin r0 = c0_rd - 32'(w1_rd); r1 = c1_rd - 32'(w2_rd); end
            default: begin r0 = c0_rd; r1 = c1_rd; end
        endcase
        f0 = j_reg.stm ? c1_rd : c0_rd;
        f1 = j_reg.stm ? c0_rd : c1_rd;
        f0 = f0[31] ? 32'd0 : f0;
        f1 = f1[31] ? 32'd0 : f1;
    end

    always_ff @(posedge aclk) begin
        if (p1_reg && j_reg.op != nnue_pkg::OP_EVAL) begin
            acc0_mem[a1_reg] <= r0;
            acc1_mem[a1_reg] <= r1;
        end
        s0_reg <= f0 * f0;
        s1_reg <= f1 * f1;
        o1_reg <= o1_rd;
        o2_reg <= o2_rd;
        m0_reg <= s0_reg * 32'(o1_reg);
        m1_reg <= s1_reg * 32'(o2_reg);
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            nnue_pkg::ST_IDLE: if (job_valid) st_next = nnue_pkg::ST_RUN;
            nnue_pkg::ST_RUN:
                if (h_reg == (nnue_pkg::HW+1)'(nnue_pkg::Hidden - 1))
                    st_next = nnue_pkg::ST_DRAIN;
            nnue_pkg::ST_DRAIN:
                if (!p1_reg && !p2_reg && !p3_reg)
                    st_next = (j_reg.op == nnue_pkg::OP_EVAL) ? nnue_pkg::ST_DIV
                                                             : nnue_pkg::ST_IDLE;
            nnue_pkg::ST_DIV: if (ph_reg == 3'd5) st_next = nnue_pkg::ST_DONE;
            nnue_pkg::ST_DONE: if (!m_valid || m_ready) st_next = nnue_pkg::ST_IDLE;
            default: st_next = nnue_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        job_ready = st_reg == nnue_pkg::ST_IDLE;
        dstart = st_reg == nnue_pkg::ST_DIV && (ph_reg == 3'd0 || ph_reg == 3'd3);
        dnum = (ph_reg == 3'd0) ? 48'($signed(sum_reg)) : t_reg;
        dden = (ph_reg == 3'd0) ? 22'(quant_a) : quant_ab;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= nnue_pkg::ST_IDLE;
            p1_reg <= 1'b0;
            p2_reg <= 1'b0;
            p3_reg <= 1'b0;
            m_valid <= 1'b0;
            ph_reg <= '0;
        end else begin
            st_reg <= st_next;
            p1_reg <= st_reg == nnue_pkg::ST_RUN;
            p2_reg <= p1_reg && j_reg.op == nnue_pkg::OP_EVAL;
            p3_reg <= p2_reg;
            m_valid <= (st_reg == nnue_pkg::ST_DONE && st_next == nnue_pkg::ST_IDLE) ||
                       (m_valid && !m_ready);
            if (st_reg != nnue_pkg::ST_DIV) ph_reg <= '0;
            else if (ph_reg == 3'd1 || ph_reg == 3'd4) begin
                if (!dbusy) ph_reg <= ph_reg + 3'd1;
            end else ph_reg <= ph_reg + 3'd1;
        end
        if (st_reg == nnue_pkg::ST_IDLE) begin
            j_reg <= job;
            h_reg <= '0;
            sum_reg <= '0;
        end
        if (st_reg == nnue_pkg::ST_RUN) h_reg <= h_reg + 1'b1;
        if (p3_reg) sum_reg <= sum_reg + m0_reg + m1_reg;
        if (st_reg == nnue_pkg::ST_DIV && ph_reg == 3'd2)
            t_reg <= (dquo + 48'(out_bias)) * $signed({1'b0, eval_scale});
        if (st_reg == nnue_pkg::ST_DONE && st_next == nnue_pkg::ST_IDLE) begin
            if (dquo > 48'sd2147483647) m_score <= 32'sh7fffffff;
            else if (dquo < -48'sd2147483648) m_score <= 32'sh80000000;
            else m_score <= dquo[31:0];
        end
    end
endmodule
`default_nettype wire

// File: rtl/nnue_accumulator_and_eval_top.sv
// Top level of the perspective accumulator and evaluator.
`default_nettype none
// Loads write the stores in the cycle they are accepted, but are held off until
// every queued and running request has finished. Reset, add, sub and eval
// requests queue (four deep) and each walks the 256 hidden entries one per
// cycle through the accumulator memory port; eval adds two serial divisions.
// Add and sub with a piece of 12 or more are dropped. The score register holds
// one result while the next request runs. Stores read undefined until loaded.
module nnue_accumulator_and_eval_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_cmd,
    input  wire logic [3:0]         s_piece,
    input  wire logic [5:0]         s_square,
    input  wire logic [17:0]        s_load_index,
    input  wire logic signed [15:0] s_load_value,
    input  wire logic               s_side_to_move,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_score,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [21:0]        cfg_data
);
    logic signed [15:0] out_bias_reg;
    logic [15:0] quant_a_reg;
    logic [21:0] quant_ab_reg;
    logic [11:0] eval_scale_reg;
    logic wr_w, wr_b, wr_o, job_valid, job_ready;
    logic [nnue_pkg::WAW-1:0] wr_addr;
    logic [15:0] wr_data;
    nnue_pkg::job_t job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_bias_reg <= '0;
            quant_a_reg <= 16'd255;
            quant_ab_reg <= 22'd16320;
            eval_scale_reg <= 12'd400;
        end else if (cfg_we) begin
            case (nnue_pkg::reg_idx_t'(cfg_index))
                nnue_pkg::REG_OUT_BIAS: out_bias_reg <= cfg_data[15:0];
                nnue_pkg::REG_QUANT_A: quant_a_reg <= cfg_data[15:0];
                nnue_pkg::REG_QUANT_AB: quant_ab_reg <= cfg_data;
                nnue_pkg::REG_SCALE: eval_scale_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    nnue_front u_front (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_cmd(s_cmd), .s_piece(s_piece), .s_square(s_square),
        .s_load_index(s_load_index), .s_load_value(s_load_value),
        .s_side_to_move(s_side_to_move), .wr_w(wr_w), .wr_b(wr_b), .wr_o(wr_o),
        .wr_addr(wr_addr), .wr_data(wr_data), .job_valid(job_valid),
        .job_ready(job_ready), .job(job)
    );

    nnue_back u_back (
        .aclk(aclk), .aresetn(aresetn), .wr_w(wr_w), .wr_b(wr_b), .wr_o(wr_o),
        .wr_addr(wr_addr), .wr_data(wr_data), .job_valid(job_valid),
        .job_ready(job_ready), .job(job), .out_bias(out_bias_reg),
        .quant_a(quant_a_reg), .quant_ab(quant_ab_reg),
        .eval_scale(eval_scale_reg), .m_valid(m_valid), .m_ready(m_ready),
        .m_score(m_score)
    );

`ifndef SYNTHESIS
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_score))
        else $error("result dropped");
    a_job: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> !job_ready)
        else $error("back end took two jobs");
`endif
endmodule
`default_nettype wire

// File: tb/nnue_accumulator_and_eval_top_tb.sv
// Self-checking testbench for the perspective accumulator and evaluator top level.
`timescale 1ns / 1ps
module nnue_accumulator_and_eval_top_tb;

    localparam int MaxCycles = 3000000;
    localparam int DrainCycles = 2000;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [2:0]         s_cmd;
    logic [3:0]         s_piece;
    logic [5:0]         s_square;
    logic [17:0]        s_load_index;
    logic signed [15:0] s_load_value;
    logic               s_side_to_move;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_score;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [21:0]        cfg_data;

    nnue_accumulator_and_eval_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_piece(s_piece),
        .s_square(s_square), .s_load_index(s_load_index), .s_load_value(s_load_value),
        .s_side_to_move(s_side_to_move),
        .m_valid(m_valid), .m_ready(m_ready), .m_score(m_score),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // mirror of the block state
    logic signed [15:0] feat_w [nnue_pkg::WDepth];
    logic signed [15:0] bias_w [nnue_pkg::Hidden];
    logic signed [15:0] out_w [2*nnue_pkg::Hidden];
    bit [31:0]          acc_us [nnue_pkg::Hidden];
    bit [31:0]          acc_them [nnue_pkg::Hidden];
    int                 out_bias_r;
    int unsigned        quant_a_r;
    int unsigned        quant_ab_r;
    int unsigned        scale_r;

    int                 score_q[$];
    int                 errors;
    int                 cycles;
    int                 send_idle;
    int                 recv_stall;
    int                 hold_left;
    int                 own_piece, own_sq, flip_piece, flip_sq;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic void update_accs(int pc, int sq, bit subtract);
        int r1, r2;
        bit [31:0] w1, w2;
        if (pc >= 12) return;
        r1 = (pc * 64 + sq) * nnue_pkg::Hidden;
        r2 = (((pc + 6) % 12) * 64 + (sq ^ 56)) * nnue_pkg::Hidden;
        for (int h = 0; h < nnue_pkg::Hidden; h++) begin
            w1 = {{16{feat_w[r1+h][15]}}, feat_w[r1+h]};
            w2 = {{16{feat_w[r2+h][15]}}, feat_w[r2+h]};
            if (subtract) begin
                acc_us[h] -= w1;
                acc_them[h] -= w2;
            end else begin
                acc_us[h] += w1;
                acc_them[h] += w2;
            end
        end
    endfunction

    function automatic int eval_score(bit stm);
        bit [31:0] sum, a, b, wa, wb;
        int sgn;
        longint t, qa, qab;
        sum = 0;
        for (int h = 0; h < nnue_pkg::Hidden; h++) begin
            a = stm ? acc_them[h] : acc_us[h];
            b = stm ? acc_us[h] : acc_them[h];
            if (a[31]) a = 0;
            if (b[31]) b = 0;
            wa = {{16{out_w[h][15]}}, out_w[h]};
            wb = {{16{out_w[nnue_pkg::Hidden+h][15]}}, out_w[nnue_pkg::Hidden+h]};
            sum += wa * (a * a);
            sum += wb * (b * b);
        end
        qa = (quant_a_r == 0) ? 1 : quant_a_r;
        qab = (quant_ab_r == 0) ? 1 : quant_ab_r;
        sgn = $signed(sum);
        t = sgn;
        t = t / qa;
        t += out_bias_r;
        t *= scale_r;
        t = t / qab;
        if (t > 64'sd2147483647) t = 64'sd2147483647;
        if (t < -64'sd2147483648) t = -64'sd2147483648;
        return int'(t);
    endfunction

    function automatic void predict(nnue_pkg::cmd_t c, int pc, int sq, int idx, int val,
                                    bit stm);
        case (c)
            nnue_pkg::CMD_LOAD_W: if (idx < nnue_pkg::WDepth) feat_w[idx] = val[15:0];
            nnue_pkg::CMD_LOAD_B: if (idx < nnue_pkg::Hidden) bias_w[idx] = val[15:0];
            nnue_pkg::CMD_LOAD_O: if (idx < 2 * nnue_pkg::Hidden) out_w[idx] = val[15:0];
            nnue_pkg::CMD_RESET: begin
                for (int h = 0; h < nnue_pkg::Hidden; h++) begin
                    acc_us[h] = {{16{bias_w[h][15]}}, bias_w[h]};
                    acc_them[h] = acc_us[h];
                end
            end
            nnue_pkg::CMD_ADD: update_accs(pc, sq, 1'b0);
            nnue_pkg::CMD_SUB: update_accs(pc, sq, 1'b1);
            nnue_pkg::CMD_EVAL: score_q.push_back(eval_score(stm));
            default: ;
        endcase
    endfunction

    task automatic send_req(nnue_pkg::cmd_t c, int pc, int sq, int idx, int val, bit stm);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_cmd = c;
        s_piece = pc[3:0];
        s_square = sq[5:0];
        s_load_index = idx[17:0];
        s_load_value = val[15:0];
        s_side_to_move = stm;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict(c, pc, sq, idx, val, stm);
        @(negedge aclk);
    endtask

    task automatic write_cfg(nnue_pkg::reg_idx_t r, int unsigned v);
        cfg_we = 1'b1;
        cfg_index = r;
        cfg_data = v[21:0];
        case (r)
            nnue_pkg::REG_OUT_BIAS: out_bias_r = $signed(v[15:0]);
            nnue_pkg::REG_QUANT_A:  quant_a_r = v[15:0];
            nnue_pkg::REG_QUANT_AB: quant_ab_r = v[21:0];
            nnue_pkg::REG_SCALE:    scale_r = v[11:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (score_q.size() != 0) @(negedge aclk);
        repeat (DrainCycles) @(negedge aclk);
    endtask

    task automatic set_cfg(int bias, int unsigned qa, int unsigned qab, int unsigned sc);
        wait_idle();
        write_cfg(nnue_pkg::REG_OUT_BIAS, bias);
        write_cfg(nnue_pkg::REG_QUANT_A, qa);
        write_cfg(nnue_pkg::REG_QUANT_AB, qab);
        write_cfg(nnue_pkg::REG_SCALE, sc);
    endtask

    function automatic int rand_word();
        case ($urandom_range(9))
            0: return 32767;
            1: return -32768;
            default: return $urandom_range(65535);
        endcase
    endfunction

    task automatic send_update(bit subtract);
        nnue_pkg::cmd_t c;
        c = subtract ? nnue_pkg::CMD_SUB : nnue_pkg::CMD_ADD;
        case ($urandom_range(9))
            0: send_req(c, $urandom_range(15, 12), $urandom_range(63), 0, 0, 0);
            1, 2, 3, 4: send_req(c, own_piece, own_sq, 0, 0, 0);
            default: send_req(c, flip_piece, flip_sq, 0, 0, 0);
        endcase
    endtask

    task automatic test_load_tables();
        int r1, r2;
        own_piece = $urandom_range(11);
        own_sq = $urandom_range(63);
        flip_piece = (own_piece + 6) % 12;
        flip_sq = own_sq ^ 56;
        r1 = (own_piece * 64 + own_sq) * nnue_pkg::Hidden;
        r2 = (flip_piece * 64 + flip_sq) * nnue_pkg::Hidden;
        for (int h = 0; h < nnue_pkg::Hidden; h++)
            send_req(nnue_pkg::CMD_LOAD_B, 0, 0, h, rand_word(), 0);
        for (int h = 0; h < 2 * nnue_pkg::Hidden; h++)
            send_req(nnue_pkg::CMD_LOAD_O, 0, 0, h, rand_word(), 0);
        for (int h = 0; h < nnue_pkg::Hidden; h++) begin
            send_req(nnue_pkg::CMD_LOAD_W, 0, 0, r1 + h, rand_word(), 0);
            send_req(nnue_pkg::CMD_LOAD_W, 0, 0, r2 + h, rand_word(), 0);
        end
    endtask

    task automatic test_directed();
        send_req(nnue_pkg::CMD_LOAD_W, 0, 0, 18'h3FFFF, -1, 0);
        send_req(nnue_pkg::CMD_LOAD_W, 0, 0, nnue_pkg::WDepth, 32767, 0);
        send_req(nnue_pkg::CMD_LOAD_B, 0, 0, nnue_pkg::Hidden, -32768, 0);
        send_req(nnue_pkg::CMD_LOAD_O, 0, 0, 2 * nnue_pkg::Hidden, 1, 0);
        send_req(nnue_pkg::CMD_RESET, 0, 0, 0, 0, 0);
        send_req(nnue_pkg::CMD_EVAL, 0, 0, 0, 0, 0);
        send_req(nnue_pkg::CMD_EVAL, 0, 0, 0, 0, 1);
        send_req(nnue_pkg::CMD_ADD, own_piece, own_sq, 0, 0, 0);
        send_req(nnue_pkg::CMD_ADD, flip_piece, flip_sq, 0, 0, 0);
        send_req(nnue_pkg::CMD_EVAL, 0, 0, 0, 0, 0);
        send_req(nnue_pkg::CMD_SUB, own_piece, own_sq, 0, 0, 0);
        send_req(nnue_pkg::CMD_ADD, 12, 0, 0, 0, 0);
        send_req(nnue_pkg::CMD_SUB, 15, 63, 0, 0, 0);
        send_req(nnue_pkg::CMD_NONE, 15, 63, 18'h3FFFF, -1, 1);
        for (int k = 0; k < 4; k++) send_req(nnue_pkg::CMD_ADD, own_piece, own_sq, 0, 0, 0);
        send_req(nnue_pkg::CMD_EVAL, 0, 0, 0, 0, 1);
        send_req(nnue_pkg::CMD_EVAL, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int n);
        int k;
        for (k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0, 1, 2: send_req(nnue_pkg::CMD_LOAD_W, 0, 0, $urandom_range(18'h3FFFF),
                                  rand_word(), 0);
                3: send_req(nnue_pkg::CMD_LOAD_W, 0, 0,
                            (own_piece * 64 + own_sq) * nnue_pkg::Hidden +
                            $urandom_range(nnue_pkg::Hidden - 1),
                            rand_word(), 0);
                4: send_req(nnue_pkg::CMD_LOAD_B, 0, 0, $urandom_range(nnue_pkg::Hidden + 20),
                            rand_word(), 0);
                5: send_req(nnue_pkg::CMD_LOAD_O, 0, 0,
                            $urandom_range(2 * nnue_pkg::Hidden + 20), rand_word(), 0);
                6: send_req(nnue_pkg::CMD_RESET, 0, 0, 0, 0, 0);
                7, 8, 9: send_update(1'b0);
                10, 11: send_update(1'b1);
                12: send_req(nnue_pkg::CMD_NONE, $urandom_range(15), $urandom_range(63),
                             $urandom_range(18'h3FFFF), rand_word(), $urandom_range(1));
                default: send_req(nnue_pkg::CMD_EVAL, $urandom_range(15), $urandom_range(63),
                                  $urandom_range(18'h3FFFF), rand_word(), $urandom_range(1));
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_left = 5000;
        for (int k = 0; k < 10; k++) begin
            send_req(nnue_pkg::CMD_EVAL, 0, 0, 0, 0, k[0]);
            send_update(k[1]);
        end
    endtask

    task automatic test_idle_phases();
        send_idle = 0;  recv_stall = 0;  test_random(120);
        set_cfg(-32768, 1, 1, 4095);
        send_idle = 66; recv_stall = 0;  test_random(120);
        set_cfg(32767, 65535, 4194303, 1);
        send_idle = 0;  recv_stall = 66; test_random(120);
        set_cfg(-1, 0, 0, 4095);
        send_idle = 19; recv_stall = 19; test_random(120);
        set_cfg($urandom_range(65535), $urandom_range(65535, 1), $urandom_range(4194303, 1),
                $urandom_range(4095, 1));
        send_idle = 0;  recv_stall = 0;  test_random(60);
    endtask

    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready = 1'b0;
        end else begin
            m_ready = ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MaxCycles) begin
            $display("nnue_accumulator_and_eval_top_tb failed");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (score_q.size() == 0) begin
                $display("%0t: unexpected score %0d", $time, m_score);
                errors++;
            end else begin
                if (m_score !== score_q[0]) begin
                    $display("%0t: score expected %0d actual %0d", $time, score_q[0], m_score);
                    errors++;
                end
                void'(score_q.pop_front());
            end
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_left = 0;
        out_bias_r = 0;
        quant_a_r = 255;
        quant_ab_r = 16320;
        scale_r = 400;
        for (int h = 0; h < nnue_pkg::Hidden; h++) begin
            acc_us[h] = 0;
            acc_them[h] = 0;
        end
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd = nnue_pkg::CMD_NONE;
        s_piece = 0;
        s_square = 0;
        s_load_index = 0;
        s_load_value = 0;
        s_side_to_move = 0;
        m_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = nnue_pkg::REG_OUT_BIAS;
        cfg_data = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        set_cfg(0, 255, 16320, 400);
        test_load_tables();
        test_directed();
        test_backpressure();
        test_idle_phases();
        wait_idle();
        if (errors == 0 && score_q.size() == 0) begin
            $display("nnue_accumulator_and_eval_top_tb passed");
        end else begin
            $display("nnue_accumulator_and_eval_top_tb failed");
        end
        $finish;
    end
endmodule
